// ===== rtl/core/stx_etx_frame_receiver_defines.svh =====
// Assertion macros used by the frame receiver RTL.
`ifndef STX_ETX_FRAME_RECEIVER_DEFINES_SVH
`define STX_ETX_FRAME_RECEIVER_DEFINES_SVH

// Checked on every rising clock edge outside of reset.
`define STXRX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define STXRX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/stxrx_pkg.sv =====
`default_nettype none
package stxrx_pkg;

  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_RESIDUE = 32'h2144_DF1C;

  // Check modes.
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_SUM  = 2'd1;
  localparam logic [1:0] MODE_CRC  = 2'd2;

  // Frame status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_STRAY   = 3'd1;
  localparam logic [2:0] ST_BAD_ESC = 3'd2;
  localparam logic [2:0] ST_SUM     = 3'd3;
  localparam logic [2:0] ST_CRC     = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_CHECK_MODE   = 3'd0;
  localparam logic [2:0] REG_START_CODE   = 3'd1;
  localparam logic [2:0] REG_END_CODE     = 3'd2;
  localparam logic [2:0] REG_ESCAPE_CODE  = 3'd3;
  localparam logic [2:0] REG_START_STUFF  = 3'd4;
  localparam logic [2:0] REG_END_STUFF    = 3'd5;
  localparam logic [2:0] REG_ESCAPE_STUFF = 3'd6;

  typedef struct packed {
    logic [1:0] check_mode;
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
    logic [7:0] start_stuff_code;
    logic [7:0] end_stuff_code;
    logic [7:0] escape_stuff_code;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       frame_end;
    logic [2:0] status;
  } result_t;

  // Reflected CRC-32 update by one byte; flattens to an XOR network.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/stxrx_decode.sv =====
`default_nettype none
module stxrx_decode (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire stxrx_pkg::cfg_t  cfg,
  input  wire logic             accept,
  input  wire logic [7:0]       rx_byte,
  output stxrx_pkg::result_t    result
);
  import stxrx_pkg::*;

  logic        in_frame;
  logic        escape_pending;
  logic        stray_start_seen;
  logic        escape_error_seen;
  logic        have_payload;
  logic [7:0]  sum_before_last;
  logic [7:0]  last_payload_byte;
  logic [31:0] crc_register;

  logic        in_frame_next;
  logic        escape_pending_next;
  logic        stray_start_seen_next;
  logic        escape_error_seen_next;
  logic        have_payload_next;
  logic [7:0]  sum_before_last_next;
  logic [7:0]  last_payload_byte_next;
  logic [31:0] crc_register_next;

  logic        emit;
  logic [7:0]  emit_byte;
  logic [2:0]  frame_status;

  always_comb begin
    frame_status = ST_OK;
    if (stray_start_seen) begin
      frame_status = ST_STRAY;
    end else if (escape_error_seen) begin
      frame_status = ST_BAD_ESC;
    end else begin
      unique case (cfg.check_mode)
        MODE_SUM: begin
          if (!have_payload || sum_before_last != last_payload_byte) frame_status = ST_SUM;
        end
        MODE_CRC: begin
          if (~crc_register != CRC_RESIDUE) frame_status = ST_CRC;
        end
        default: frame_status = ST_OK;
      endcase
    end
  end

  always_comb begin
    in_frame_next          = in_frame;
    escape_pending_next    = escape_pending;
    stray_start_seen_next  = stray_start_seen;
    escape_error_seen_next = escape_error_seen;
    have_payload_next      = have_payload;
    sum_before_last_next   = sum_before_last;
    last_payload_byte_next = last_payload_byte;
    crc_register_next      = crc_register;
    emit                   = 1'b0;
    emit_byte              = rx_byte;
    result                 = '0;

    if (!in_frame) begin
      // Opening a frame restarts all per-frame state.
      if (rx_byte == cfg.start_code) begin
        in_frame_next          = 1'b1;
        escape_pending_next    = 1'b0;
        stray_start_seen_next  = 1'b0;
        escape_error_seen_next = 1'b0;
        have_payload_next      = 1'b0;
        sum_before_last_next   = 8'd0;
        last_payload_byte_next = 8'd0;
        crc_register_next      = '1;
      end
    end else if (rx_byte == cfg.end_code) begin
      result.valid        = 1'b1;
      result.frame_end    = 1'b1;
      result.status       = frame_status;
      in_frame_next       = 1'b0;
      escape_pending_next = 1'b0;
    end else if (rx_byte == cfg.start_code) begin
      stray_start_seen_next = 1'b1;
    end else if (rx_byte == cfg.escape_code) begin
      escape_pending_next = 1'b1;
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      if (rx_byte == cfg.start_stuff_code) begin
        emit      = 1'b1;
        emit_byte = cfg.start_code;
      end else if (rx_byte == cfg.end_stuff_code) begin
        emit      = 1'b1;
        emit_byte = cfg.end_code;
      end else if (rx_byte == cfg.escape_stuff_code) begin
        emit      = 1'b1;
        emit_byte = cfg.escape_code;
      end else begin
        escape_error_seen_next = 1'b1;
      end
    end else begin
      emit = 1'b1;
    end

    if (emit) begin
      if (have_payload) sum_before_last_next = sum_before_last + last_payload_byte;
      last_payload_byte_next = emit_byte;
      have_payload_next      = 1'b1;
      crc_register_next      = crc_byte(crc_register, emit_byte);
      result.valid           = 1'b1;
      result.data            = emit_byte;
    end

    if (!accept) result.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame          <= 1'b0;
      escape_pending    <= 1'b0;
      stray_start_seen  <= 1'b0;
      escape_error_seen <= 1'b0;
      have_payload      <= 1'b0;
      sum_before_last   <= 8'd0;
      last_payload_byte <= 8'd0;
      crc_register      <= '1;
    end else if (accept) begin
      in_frame          <= in_frame_next;
      escape_pending    <= escape_pending_next;
      stray_start_seen  <= stray_start_seen_next;
      escape_error_seen <= escape_error_seen_next;
      have_payload      <= have_payload_next;
      sum_before_last   <= sum_before_last_next;
      last_payload_byte <= last_payload_byte_next;
      crc_register      <= crc_register_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/stx_etx_frame_receiver.sv =====
// Byte-stuffed frame receiver with optional checksum or CRC-32 check.
// Input channel (in_valid/in_ready, rx_byte) takes one raw link byte per
// transfer. Output channel (out_valid/out_ready) gives one result per payload
// byte (out_byte, frame_end 0, status 0) and one closing result per frame
// (out_byte 0, frame_end 1, status). Bytes outside a frame give no result.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready. The user must write it only while the receiver is idle; the
// block does not enforce this. A result is registered when its byte is taken.
// Throughput: one byte per cycle while in_ready is high, bounded by the
// combinational unstuff and byte-wide CRC update before the output register.
// The output has a register and a one-entry skid stage; in_ready depends only
// on the skid stage, so when the sink stalls, input continues until both
// entries hold results, then in_ready drops until the sink takes one.
// Reset (rst, synchronous) loads the default codes, no check, clears the
// frame state and empties both output entries.
`default_nettype none
`include "stx_etx_frame_receiver_defines.svh"
module stx_etx_frame_receiver (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            frame_end,
  output logic [2:0]      status,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import stxrx_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t out_q;
  result_t skid_q;
  logic    in_accept;
  logic    out_take;
  logic    out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_q.valid;
  assign in_accept = in_valid && in_ready;
  assign out_take  = out_q.valid && out_ready;
  assign out_free  = !out_q.valid || out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_mode        <= MODE_NONE;
      cfg.start_code        <= 8'd255;
      cfg.end_code          <= 8'd254;
      cfg.escape_code       <= 8'd253;
      cfg.start_stuff_code  <= 8'd0;
      cfg.end_stuff_code    <= 8'd1;
      cfg.escape_stuff_code <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHECK_MODE:   cfg.check_mode        <= cfg_data[1:0];
        REG_START_CODE:   cfg.start_code        <= cfg_data;
        REG_END_CODE:     cfg.end_code          <= cfg_data;
        REG_ESCAPE_CODE:  cfg.escape_code       <= cfg_data;
        REG_START_STUFF:  cfg.start_stuff_code  <= cfg_data;
        REG_END_STUFF:    cfg.end_stuff_code    <= cfg_data;
        REG_ESCAPE_STUFF: cfg.escape_stuff_code <= cfg_data;
        default: ;
      endcase
    end
  end

  stxrx_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (in_accept),
    .rx_byte (rx_byte),
    .result  (result)
  );

  // The skid entry is always older than a new result, so it drains first.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_q.valid  <= 1'b0;
      skid_q.valid <= 1'b0;
    end else if (skid_q.valid && out_free) begin
      out_q        <= skid_q;
      skid_q.valid <= 1'b0;
    end else if (result.valid) begin
      if (out_free) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end else if (out_take) begin
      out_q.valid <= 1'b0;
    end
  end

  assign out_valid = out_q.valid;
  assign out_byte  = out_q.data;
  assign frame_end = out_q.frame_end;
  assign status    = out_q.status;

  `STXRX_ASSERT_ALWAYS(a_skid_behind_out, skid_q.valid |-> out_q.valid, "skid entry without output entry")
  `STXRX_ASSERT(a_end_byte_zero, (out_valid && frame_end) |-> (out_byte == 8'd0), "closing result has nonzero byte")
  `STXRX_ASSERT(a_payload_status_ok, (out_valid && !frame_end) |-> (status == ST_OK), "payload result carries a status")

endmodule
`default_nettype wire
